// ===== src/rlzc_pkg.sv =====
// ----------------------------------------------------------------------------
// rlzc_pkg
// Types, constants and helpers shared by the row Laplacian zero-crossing block.
// ----------------------------------------------------------------------------
package rlzc_pkg;

    localparam int CFG_W = 12;

    typedef enum logic {
        CFG_ROW_LENGTH = 1'b0,
        CFG_ROW_COUNT  = 1'b1
    } t_cfg_idx;

    localparam int unsigned MIN_ROW_LENGTH = 4;
    localparam int unsigned MIN_ROW_COUNT  = 3;
    localparam int unsigned RST_ROW_LENGTH = 640;
    localparam int unsigned RST_ROW_COUNT  = 480;

    localparam logic [7:0] WHITE = 8'd255;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;
    localparam int Q_CW    = 3;
    localparam int N_PUSH  = 3;

    typedef struct packed {
        logic [7:0] first_channel;
        logic [7:0] second_channel;
        logic [7:0] blue_channel;
    } t_in_item;

    typedef struct packed {
        logic [7:0] first_channel_out;
        logic [7:0] second_channel_out;
        logic [7:0] blue_channel_out;
        logic       zero_cross_mark;
        logic       row_end;
        logic       frame_end;
    } t_out_item;

    typedef struct packed {
        logic [1:0]                   n;
        t_out_item [N_PUSH-1:0]       item;
    } t_push;

    function automatic t_out_item make_out(t_in_item px, logic mark, logic rend,
                                           logic fend);
        t_out_item r;
        r.first_channel_out  = mark ? WHITE : px.first_channel;
        r.second_channel_out = mark ? WHITE : px.second_channel;
        r.blue_channel_out   = mark ? WHITE : px.blue_channel;
        r.zero_cross_mark    = mark;
        r.row_end            = rend;
        r.frame_end          = fend;
        return r;
    endfunction

endpackage

// ===== src/rlzc_cell.sv =====
// ----------------------------------------------------------------------------
// rlzc_cell
// One pixel cell of the row history chain; loads its neighbour on a shift.
// ----------------------------------------------------------------------------
module rlzc_cell (
    input  logic              i_clk,
    input  logic              i_shift,
    input  rlzc_pkg::t_in_item i_px,
    output rlzc_pkg::t_in_item o_px
);
    import rlzc_pkg::*;

    t_in_item r_px;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_px <= i_px;
        end
    end

    assign o_px = r_px;

endmodule

// ===== src/rlzc_queue.sv =====
// ----------------------------------------------------------------------------
// rlzc_queue
// Four-entry result queue taking up to three results per cycle, one out.
// ----------------------------------------------------------------------------
module rlzc_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rlzc_pkg::t_push     i_push,
    output logic                o_room,
    output logic                o_valid,
    input  logic                i_ready,
    output rlzc_pkg::t_out_item o_data
);
    import rlzc_pkg::*;

    t_out_item         r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr, n_wr;
    logic [Q_AW-1:0]   r_rd, n_rd;
    logic [Q_CW-1:0]   r_cnt, n_cnt;
    logic              pop;

    assign pop     = (r_cnt != '0) && i_ready;
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    // room for a full three-result burst
    assign o_room  = (r_cnt <= Q_CW'(1));

    always_comb begin
        n_wr  = r_wr + Q_AW'(i_push.n);
        n_rd  = r_rd + Q_AW'(pop);
        n_cnt = r_cnt + Q_CW'(i_push.n) - Q_CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < N_PUSH; k++) begin
            if (2'(k) < i_push.n) begin
                r_mem[r_wr + Q_AW'(k)] <= i_push.item[k];
            end
        end
    end

endmodule

// ===== src/row_laplacian_zero_crossing.sv =====
// ----------------------------------------------------------------------------
// row_laplacian_zero_crossing
// Marks horizontal zero crossings of the blue second difference in a stream.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on i_in_* in raster order (valid/ready) and leave on o_out_*
//   (valid/ready). Each transaction in yields no result in columns 0 and 1,
//   one result (the pixel two columns back) in later columns, and three
//   results on the last column of a row, the last flagged row_end (and
//   frame_end on the last row of the frame).
//   A result is registered in the output queue before it is visible on
//   o_out_*. Input runs at one pixel per cycle while the queue has room;
//   after the three-result burst at each row end, input is held off until
//   the queue is back to one entry.
//   A three-cell shift chain holds the pixel history; a four-entry queue
//   decouples the output, and o_in_ready drops while it holds two or more.
//   When the receiver stalls the queue fills and input is held off; nothing
//   is lost. Reset clears positions and the queue and loads row_length 640,
//   row_count 480. The user must write registers via i_cfg_* only while the
//   block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module row_laplacian_zero_crossing #(
    parameter int MAX_ROW_LENGTH = 2048,
    parameter int MAX_ROW_COUNT  = 2048
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  rlzc_pkg::t_cfg_idx            i_cfg_idx,
    input  logic [rlzc_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  rlzc_pkg::t_in_item            i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output rlzc_pkg::t_out_item           o_out_data
);
    import rlzc_pkg::*;

    localparam int CW = $clog2(MAX_ROW_LENGTH);
    localparam int RW = $clog2(MAX_ROW_COUNT);
    localparam int unsigned MAXL = MAX_ROW_LENGTH;
    localparam int unsigned MAXC = MAX_ROW_COUNT;
    localparam int unsigned LEN_RST = (RST_ROW_LENGTH > MAXL) ? MAXL : RST_ROW_LENGTH;
    localparam int unsigned CNT_RST = (RST_ROW_COUNT > MAXC) ? MAXC : RST_ROW_COUNT;
    localparam logic [CW-1:0] LEN_LAST_RST = CW'(LEN_RST - 1);
    localparam logic [RW-1:0] CNT_LAST_RST = RW'(CNT_RST - 1);

    logic [CW-1:0] r_len_last, n_len_last;
    logic [RW-1:0] r_cnt_last, n_cnt_last;
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;

    int unsigned   cfg_v, len_c, cnt_c;
    logic          in_acc, last_col, last_row, inner_row, col_ge2, col_ge3;
    logic          mark, room;
    logic [8:0]    s1, s2, tw1, tw2;
    logic          d1_neg, d1_pos, d2_neg, d2_pos;
    t_in_item      chain [4];
    t_push         push;

    // --- configuration, stored as saturated last index ---
    always_comb begin
        cfg_v      = 32'(i_cfg_data);
        len_c      = (cfg_v < MIN_ROW_LENGTH) ? MIN_ROW_LENGTH :
                     (cfg_v > MAXL) ? MAXL : cfg_v;
        cnt_c      = (cfg_v < MIN_ROW_COUNT) ? MIN_ROW_COUNT :
                     (cfg_v > MAXC) ? MAXC : cfg_v;
        n_len_last = r_len_last;
        n_cnt_last = r_cnt_last;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ROW_LENGTH: n_len_last = CW'(len_c - 1);
                CFG_ROW_COUNT:  n_cnt_last = RW'(cnt_c - 1);
                default: ;
            endcase
        end
    end

    // --- history chain: chain[1] newest, chain[3] oldest ---
    assign chain[0] = i_in_data;

    for (genvar g = 0; g < 3; g++) begin : g_cell
        rlzc_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (in_acc),
            .i_px    (chain[g]),
            .o_px    (chain[g+1])
        );
    end

    assign o_in_ready = room;
    assign in_acc     = i_in_valid && room;

    always_comb begin
        last_col  = (r_col >= r_len_last);
        last_row  = (r_row >= r_cnt_last);
        inner_row = (r_row != '0) && !last_row;
        col_ge2   = (r_col >= CW'(2));
        col_ge3   = (r_col >= CW'(3));

        // d1 = b[x+1] + b[x-1] - 2b[x], d2 = b[x+2] + b[x] - 2b[x+1]
        s1  = {1'b0, chain[1].blue_channel} + {1'b0, chain[3].blue_channel};
        tw1 = {chain[2].blue_channel, 1'b0};
        s2  = {1'b0, chain[0].blue_channel} + {1'b0, chain[2].blue_channel};
        tw2 = {chain[1].blue_channel, 1'b0};
        d1_neg = s1 < tw1;
        d1_pos = s1 > tw1;
        d2_neg = s2 < tw2;
        d2_pos = s2 > tw2;
        mark   = inner_row && col_ge3 && ((d1_neg && d2_pos) || (d1_pos && d2_neg));

        push.item[0] = make_out(chain[2], mark, 1'b0, 1'b0);
        push.item[1] = make_out(chain[1], 1'b0, 1'b0, 1'b0);
        push.item[2] = make_out(chain[0], 1'b0, 1'b1, last_row);
        if (!in_acc || !col_ge2) begin
            push.n = 2'd0;
        end else if (last_col) begin
            push.n = 2'd3;
        end else begin
            push.n = 2'd1;
        end

        n_col = r_col;
        n_row = r_row;
        if (in_acc) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : r_row + RW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_last <= LEN_LAST_RST;
            r_cnt_last <= CNT_LAST_RST;
            r_col      <= '0;
            r_row      <= '0;
        end else begin
            r_len_last <= n_len_last;
            r_cnt_last <= n_cnt_last;
            r_col      <= n_col;
            r_row      <= n_row;
        end
    end

    rlzc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule

// ===== src/rlzc_checker.sv =====
// ----------------------------------------------------------------------------
// rlzc_checker
// Port-level checks for the row Laplacian zero-crossing block.
// ----------------------------------------------------------------------------
module rlzc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input rlzc_pkg::t_in_item            i_in_data,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input rlzc_pkg::t_out_item           o_out_data
);
    import rlzc_pkg::*;

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_data))
        else $error("input transaction changed while waiting");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output transaction dropped while stalled");

    a_frame_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.frame_end |-> o_out_data.row_end)
        else $error("frame_end without row_end");

    a_mark_white: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.zero_cross_mark |->
            o_out_data.first_channel_out == WHITE &&
            o_out_data.second_channel_out == WHITE &&
            o_out_data.blue_channel_out == WHITE)
        else $error("marked pixel not white");

    a_mark_border: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.row_end |-> !o_out_data.zero_cross_mark)
        else $error("row end pixel marked");

endmodule

bind row_laplacian_zero_crossing rlzc_checker u_rlzc_checker (.*);
